>>> rtl/core/tsd_pkg.sv
// Shared types, widths and constants for the timestamp difference pipeline.
// No dependencies; used by tsd_stamp and timestamp_difference.

package tsd_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int STAMP_W  = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;

    localparam int HOURS_W  = 27;
    localparam int DIFF_W   = 6;

    // Internal widths
    localparam int DAYS_W   = 23;   // signed day count, -1 .. about 3.65M
    localparam int DDIFF_W  = 22;   // day difference magnitude
    localparam int TOD_W    = 17;   // seconds within a day (and raw time of day)
    localparam int REM_W    = 12;   // seconds within an hour

    // Calendar limits
    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    localparam logic [TOD_W-1:0] SEC_PER_DAY  = 17'd86400;
    localparam int               SEC_PER_HOUR = 3600;
    localparam int               SEC_PER_MIN  = 60;
    localparam int               DAYS_PER_YR  = 365;
    localparam int               HRS_PER_DAY  = 24;

    // Reciprocal multipliers: floor(x / d) = (x * RECIP) >> SHIFT over the used range
    localparam int RECIP100   = 5243;
    localparam int SHIFT100   = 19;
    localparam int RECIP3600  = 149131;
    localparam int SHIFT3600  = 29;
    localparam int RECIP60    = 2185;
    localparam int SHIFT60    = 17;

    // Pipeline depth of the top level
    localparam int NSTAGE = 8;

    typedef logic signed [DAYS_W-1:0] tsd_days_t;
    typedef logic [TOD_W-1:0]         tsd_tod_t;

    // Per-stage load enables for the stamp converter
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } tsd_ctrl_t;

    // Days in the year before the first of the given month
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/core/tsd_stamp.sv
// Three-stage converter from one date-time to a day count and seconds of day.
// Depends on tsd_pkg; instantiated twice by timestamp_difference.

module tsd_stamp
(
    input  logic                            clk,
    input  tsd_pkg::tsd_ctrl_t              ctrl,
    input  logic [tsd_pkg::YEAR_W-1:0]      year,
    input  logic [tsd_pkg::MONTH_W-1:0]     month,
    input  logic [tsd_pkg::DAY_W-1:0]       day,
    input  logic [tsd_pkg::HOUR_W-1:0]      hour,
    input  logic [tsd_pkg::MINUTE_W-1:0]    minute,
    input  logic [tsd_pkg::SECOND_W-1:0]    second,
    output tsd_pkg::tsd_days_t              days,
    output tsd_pkg::tsd_tod_t               secs
);

    // ---------------- stage 1: clamp, reciprocal products, time of day
    logic [tsd_pkg::YEAR_W-1:0]  y_c;
    logic [tsd_pkg::MONTH_W-1:0] m_c;
    logic [tsd_pkg::YEAR_W-1:0]  p_c;

    logic [tsd_pkg::YEAR_W-1:0]  y1_reg, p1_reg;
    logic [tsd_pkg::MONTH_W-1:0] m1_reg;
    logic [tsd_pkg::DAY_W-1:0]   d1_reg;
    logic [25:0]                 py100_reg, py100_next;
    logic [23:0]                 p400_reg, p400_next;
    logic [25:0]                 y100_reg, y100_next;
    logic [tsd_pkg::TOD_W-1:0]   tod1_reg, tod1_next;

    // Clamp year and month into the calendar
    always_comb
    begin
        if (year == '0)
            y_c = 14'd1;
        else if (year > tsd_pkg::MAX_YEAR)
            y_c = tsd_pkg::MAX_YEAR;
        else
            y_c = year;

        if (month == '0)
            m_c = tsd_pkg::MONTH_JAN;
        else if (month > tsd_pkg::MONTH_DEC)
            m_c = tsd_pkg::MONTH_DEC;
        else
            m_c = month;

        p_c = y_c - 14'd1;
    end

    assign py100_next = 26'(p_c) * 26'(tsd_pkg::RECIP100);
    assign p400_next  = 24'(p_c >> 2) * 24'(tsd_pkg::RECIP100);
    assign y100_next  = 26'(y_c) * 26'(tsd_pkg::RECIP100);
    assign tod1_next  = 17'(hour) * 17'(tsd_pkg::SEC_PER_HOUR)
                      + 17'(minute) * 17'(tsd_pkg::SEC_PER_MIN)
                      + 17'(second);

    always_ff @(posedge clk)
    begin
        if (ctrl.ld1)
        begin
            y1_reg    <= y_c;
            p1_reg    <= p_c;
            m1_reg    <= m_c;
            d1_reg    <= day;
            py100_reg <= py100_next;
            p400_reg  <= p400_next;
            y100_reg  <= y100_next;
            tod1_reg  <= tod1_next;
        end
    end

    // ---------------- stage 2: leap test, year base, month offset, day spill
    logic [6:0]                  q100, yq;
    logic [4:0]                  q400;
    logic [tsd_pkg::YEAR_W-1:0]  yr100;
    logic                        leap;

    logic [tsd_pkg::DDIFF_W-1:0] base2_reg, base2_next;
    logic [8:0]                  mo2_reg, mo2_next;
    logic [tsd_pkg::DAY_W-1:0]   d2_reg;
    logic                        k2_reg, k2_next;
    logic [tsd_pkg::TOD_W-1:0]   r2_reg, r2_next;

    assign q100  = py100_reg[tsd_pkg::SHIFT100 +: 7];
    assign q400  = p400_reg[tsd_pkg::SHIFT100 +: 5];
    assign yq    = y100_reg[tsd_pkg::SHIFT100 +: 7];
    assign yr100 = y1_reg - 14'(yq) * 14'd100;

    // Divisible by 4, and not by 100 unless by 400
    assign leap = (y1_reg[1:0] == 2'b00) && ((yr100 != '0) || (yq[1:0] == 2'b00));

    assign base2_next = 22'(p1_reg) * 22'(tsd_pkg::DAYS_PER_YR)
                      + 22'(p1_reg >> 2) - 22'(q100) + 22'(q400);
    assign mo2_next   = tsd_pkg::days_before(m1_reg)
                      + 9'((m1_reg > tsd_pkg::MONTH_FEB) && leap);

    // Fold an overlong time of day into the next day
    always_comb
    begin
        if (tod1_reg >= tsd_pkg::SEC_PER_DAY)
        begin
            k2_next = 1'b1;
            r2_next = tod1_reg - tsd_pkg::SEC_PER_DAY;
        end
        else
        begin
            k2_next = 1'b0;
            r2_next = tod1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld2)
        begin
            base2_reg <= base2_next;
            mo2_reg   <= mo2_next;
            d2_reg    <= d1_reg;
            k2_reg    <= k2_next;
            r2_reg    <= r2_next;
        end
    end

    // ---------------- stage 3: final day count
    logic [tsd_pkg::DAYS_W-1:0] dsum;
    tsd_pkg::tsd_days_t         days3_reg, days3_next;
    tsd_pkg::tsd_tod_t          r3_reg;

    assign dsum       = 23'(base2_reg) + 23'(mo2_reg) + 23'(d2_reg) + 23'(k2_reg);
    assign days3_next = $signed(dsum) - 23'sd1;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld3)
        begin
            days3_reg <= days3_next;
            r3_reg    <= r2_reg;
        end
    end

    assign days = days3_reg;
    assign secs = r3_reg;

endmodule

>>> rtl/core/timestamp_difference.sv
// Absolute difference of two Gregorian date-times, as hours, minutes, seconds.
// Depends on tsd_pkg and tsd_stamp.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one word holding
//   both date-times; the master channel (m_tvalid, m_tready, m_tdata) gives
//   one word per input word with the difference in whole hours, then the
//   remaining minutes and seconds. Words leave in the order they arrived.
//   One word is taken every cycle while the receiver keeps up. Each word
//   passes through the eight-stage pipeline: two stamp converters side by
//   side for stages one to three, then compare, subtract and reciprocal
//   division by 3600 and 60, the last stage holding the output register.
//   Each stage holds its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up. When the receiver stalls,
//   the last stage holds its word and the stages behind it fill; s_tready
//   drops only once all eight stages hold a word.
//   Reset clears all valid bits; the block then accepts at once. The block
//   keeps no state between words.

module timestamp_difference
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // first_year, first_month, first_day, first_hour, first_minute,
    // first_second, second_year, second_month, second_day, second_hour,
    // second_minute, second_second
    input  logic [79:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // diff_hours, diff_minutes, diff_seconds, one zero pad bit
    output logic [39:0] m_tdata
);

    localparam int N = tsd_pkg::NSTAGE;

    // ---------------- stage flow control
    logic [N:1]   vld_reg;
    logic [N+1:1] adv;

    always_comb
    begin
        adv[N+1] = m_tready;
        for (int i = N; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
                vld_reg[1] <= s_tvalid;
            for (int i = 2; i <= N; i++)
            begin
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------- stages 1 to 3: convert each date-time
    tsd_pkg::tsd_ctrl_t ctrl;
    tsd_pkg::tsd_days_t days_a, days_b;
    tsd_pkg::tsd_tod_t  tod_a, tod_b;

    assign ctrl.ld1 = adv[1];
    assign ctrl.ld2 = adv[2];
    assign ctrl.ld3 = adv[3];

    tsd_stamp u_stamp_a
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .year   (s_tdata[13:0]),
        .month  (s_tdata[17:14]),
        .day    (s_tdata[22:18]),
        .hour   (s_tdata[27:23]),
        .minute (s_tdata[33:28]),
        .second (s_tdata[39:34]),
        .days   (days_a),
        .secs   (tod_a)
    );

    tsd_stamp u_stamp_b
    (
        .clk    (clk),
        .ctrl   (ctrl),
        .year   (s_tdata[53:40]),
        .month  (s_tdata[57:54]),
        .day    (s_tdata[62:58]),
        .hour   (s_tdata[67:63]),
        .minute (s_tdata[73:68]),
        .second (s_tdata[79:74]),
        .days   (days_b),
        .secs   (tod_b)
    );

    // ---------------- stage 4: order the pair and subtract with borrow
    logic                        b_ge_a;
    tsd_pkg::tsd_days_t          big_d, sml_d, dd_raw;
    tsd_pkg::tsd_tod_t           big_r, sml_r;
    logic signed [17:0]          dr_raw;
    logic [tsd_pkg::DAYS_W-1:0]  dd_fix;
    logic [tsd_pkg::DDIFF_W-1:0] dd4_reg, dd4_next;
    logic [tsd_pkg::TOD_W-1:0]   dr4_reg, dr4_next;

    assign b_ge_a = (days_b > days_a) || ((days_b == days_a) && (tod_b >= tod_a));

    always_comb
    begin
        if (b_ge_a)
        begin
            big_d = days_b;
            big_r = tod_b;
            sml_d = days_a;
            sml_r = tod_a;
        end
        else
        begin
            big_d = days_a;
            big_r = tod_a;
            sml_d = days_b;
            sml_r = tod_b;
        end

        dd_raw = big_d - sml_d;
        dr_raw = $signed({1'b0, big_r}) - $signed({1'b0, sml_r});

        // Borrow a day when the seconds part goes negative
        if (dr_raw < 0)
        begin
            dd_fix   = dd_raw - 23'd1;
            dr4_next = 17'(dr_raw + 18'sd86400);
        end
        else
        begin
            dd_fix   = dd_raw;
            dr4_next = dr_raw[tsd_pkg::TOD_W-1:0];
        end
        dd4_next = dd_fix[tsd_pkg::DDIFF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            dd4_reg <= dd4_next;
            dr4_reg <= dr4_next;
        end
    end

    // ---------------- stage 5: hours from days, reciprocal product for /3600
    logic [tsd_pkg::HOURS_W-1:0] hb5_reg, hb5_next;
    logic [33:0]                 ph5_reg, ph5_next;
    logic [tsd_pkg::TOD_W-1:0]   dr5_reg;

    assign hb5_next = 27'(dd4_reg) * 27'(tsd_pkg::HRS_PER_DAY);
    assign ph5_next = 34'(dr4_reg) * 34'(tsd_pkg::RECIP3600);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            hb5_reg <= hb5_next;
            ph5_reg <= ph5_next;
            dr5_reg <= dr4_reg;
        end
    end

    // ---------------- stage 6: whole hours and remainder within the hour
    logic [4:0]                  qh;
    logic [tsd_pkg::TOD_W-1:0]   rem_full;
    logic [tsd_pkg::HOURS_W-1:0] hr6_reg, hr6_next;
    logic [tsd_pkg::REM_W-1:0]   rem6_reg, rem6_next;

    assign qh        = ph5_reg[tsd_pkg::SHIFT3600 +: 5];
    assign rem_full  = dr5_reg - 17'(qh) * 17'(tsd_pkg::SEC_PER_HOUR);
    assign rem6_next = rem_full[tsd_pkg::REM_W-1:0];
    assign hr6_next  = hb5_reg + 27'(qh);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            hr6_reg  <= hr6_next;
            rem6_reg <= rem6_next;
        end
    end

    // ---------------- stage 7: reciprocal product for /60
    logic [tsd_pkg::HOURS_W-1:0] hr7_reg;
    logic [tsd_pkg::REM_W-1:0]   rem7_reg;
    logic [22:0]                 pm7_reg, pm7_next;

    assign pm7_next = 23'(rem6_reg) * 23'(tsd_pkg::RECIP60);

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            hr7_reg  <= hr6_reg;
            rem7_reg <= rem6_reg;
            pm7_reg  <= pm7_next;
        end
    end

    // ---------------- stage 8: minutes and seconds, output register
    logic [tsd_pkg::DIFF_W-1:0]  mn;
    logic [tsd_pkg::REM_W-1:0]   sec_full;
    logic [tsd_pkg::HOURS_W-1:0] hr8_reg;
    logic [tsd_pkg::DIFF_W-1:0]  mn8_reg, sc8_reg, sc8_next;

    assign mn       = pm7_reg[tsd_pkg::SHIFT60 +: tsd_pkg::DIFF_W];
    assign sec_full = rem7_reg - 12'(mn) * 12'(tsd_pkg::SEC_PER_MIN);
    assign sc8_next = sec_full[tsd_pkg::DIFF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            hr8_reg <= hr7_reg;
            mn8_reg <= mn;
            sc8_reg <= sc8_next;
        end
    end

    assign m_tvalid = vld_reg[N];
    assign m_tdata  = {1'b0, sc8_reg, mn8_reg, hr8_reg};

`ifndef SYNTH
    // An empty output stage means the whole pipe can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    // Normalised seconds of day stay below one day
    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (tod_a < tsd_pkg::SEC_PER_DAY) && (tod_b < tsd_pkg::SEC_PER_DAY))
        else $error("seconds of day out of range");

    // Remainder within the hour is below 3600
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] |-> (rem6_reg < 12'd3600))
        else $error("remainder within hour out of range");

    // Minutes and seconds of a delivered word are below 60
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32:27] < 6'd60) && (m_tdata[38:33] < 6'd60))
        else $error("minutes or seconds out of range");
`endif

endmodule

>>> tb/timestamp_difference_tb.sv
// Testbench for timestamp_difference: drives timestamp-pair words, predicts
// each difference in hours, minutes and seconds, and checks the result words.
// Depends on tsd_pkg and the timestamp_difference RTL.

module timestamp_difference_tb;

    localparam int RANDOM_PAIRS  = 400;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 100;
    localparam int HOLD_AT       = 140;
    localparam int DRAIN_AT      = 330;
    localparam int BURST_FROM    = 130;
    localparam int BURST_TO      = 270;
    localparam int SETTLE_CYCLES = tsd_pkg::NSTAGE * 4;

    // One date-time, lowest field in the lowest bits
    typedef struct packed {
        logic [tsd_pkg::SECOND_W-1:0] sec;
        logic [tsd_pkg::MINUTE_W-1:0] minute;
        logic [tsd_pkg::HOUR_W-1:0]   hour;
        logic [tsd_pkg::DAY_W-1:0]    day;
        logic [tsd_pkg::MONTH_W-1:0]  month;
        logic [tsd_pkg::YEAR_W-1:0]   year;
    } stamp_t;

    typedef struct packed {
        stamp_t later;
        stamp_t earlier;
    } stamp_pair_t;

    // Result word: hours in the lowest bits, one pad bit on top
    typedef struct packed {
        logic                        pad;
        logic [tsd_pkg::DIFF_W-1:0]  secs;
        logic [tsd_pkg::DIFF_W-1:0]  mins;
        logic [tsd_pkg::HOURS_W-1:0] hours;
    } diff_word_t;

    typedef struct packed {
        stamp_pair_t pair;
        logic        drain_first;
        logic [7:0]  gap_after;
    } pair_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    pair_item_t  pending_pairs[$];
    diff_word_t  expected_diffs[$];

    logic        acc_valid = 1'b0;
    logic [79:0] acc_word = '0;
    int          n_acc = 0;
    int          n_got = 0;
    int          n_err = 0;
    int          n_wild = 0;
    int          cyc = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    timestamp_difference DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Seconds since 0001-01-01 00:00:00, with out-of-range year and month clamped
    function automatic longint stamp_to_seconds(input stamp_t s);
        longint y;
        longint m;
        longint p;
        longint days;
        longint month_base;
        y = s.year;
        m = s.month;
        if (y < 1)
            y = 1;
        if (y > tsd_pkg::MAX_YEAR)
            y = tsd_pkg::MAX_YEAR;
        if (m < 1)
            m = 1;
        if (m > 12)
            m = 12;
        case (m)
            1:       month_base = 0;
            2:       month_base = 31;
            3:       month_base = 59;
            4:       month_base = 90;
            5:       month_base = 120;
            6:       month_base = 151;
            7:       month_base = 181;
            8:       month_base = 212;
            9:       month_base = 243;
            10:      month_base = 273;
            11:      month_base = 304;
            default: month_base = 334;
        endcase
        p = y - 1;
        days = 365 * p + p / 4 - p / 100 + p / 400 + month_base;
        if (m > 2 && (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0))
            days = days + 1;
        days = days + longint'(s.day) - 1;
        return days * 86400 + longint'(s.hour) * 3600 + longint'(s.minute) * 60
               + longint'(s.sec);
    endfunction

    function automatic diff_word_t predict_difference(input stamp_pair_t pr);
        longint     d;
        longint     q;
        diff_word_t r;
        d = stamp_to_seconds(pr.later) - stamp_to_seconds(pr.earlier);
        if (d < 0)
            d = -d;
        r.pad   = 1'b0;
        q       = d / 3600;
        r.hours = q[tsd_pkg::HOURS_W-1:0];
        q       = (d % 3600) / 60;
        r.mins  = q[tsd_pkg::DIFF_W-1:0];
        q       = d % 60;
        r.secs  = q[tsd_pkg::DIFF_W-1:0];
        return r;
    endfunction

    function automatic stamp_t mk(input int y, input int mo, input int d, input int h,
                                  input int mi, input int s);
        stamp_t t;
        t.year   = y[tsd_pkg::YEAR_W-1:0];
        t.month  = mo[tsd_pkg::MONTH_W-1:0];
        t.day    = d[tsd_pkg::DAY_W-1:0];
        t.hour   = h[tsd_pkg::HOUR_W-1:0];
        t.minute = mi[tsd_pkg::MINUTE_W-1:0];
        t.sec    = s[tsd_pkg::SECOND_W-1:0];
        return t;
    endfunction

    // Plausible date-time, years often at either end of the range or on a century
    function automatic stamp_t random_stamp();
        int r;
        int y;
        r = $urandom_range(0, 99);
        if (r < 10)
            y = $urandom_range(1, 3);
        else if (r < 20)
            y = $urandom_range(9996, 9999);
        else if (r < 30)
            y = 400 * $urandom_range(1, 24) + $urandom_range(0, 1) * 100;
        else
            y = $urandom_range(1, 9999);
        return mk(y, $urandom_range(1, 12),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28),
                  $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    // Any bit pattern at all in every field
    function automatic stamp_t wild_stamp();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[tsd_pkg::STAMP_W-1:0];
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic add_pair(input stamp_t a, input stamp_t b);
        pair_item_t it;
        it.pair.earlier = a;
        it.pair.later   = b;
        it.drain_first  = (pending_pairs.size() == DRAIN_AT);
        if (pending_pairs.size() >= BURST_FROM && pending_pairs.size() < BURST_TO)
            it.gap_after = '0;
        else
            it.gap_after = 8'(pick_gap());
        pending_pairs.push_back(it);
    endtask

    // Stimulus, then wait for the pipeline to empty and report
    initial
    begin
        stamp_t a;
        stamp_t b;
        int     r;
        int     v;

        // Directed: extremes, leap rules and out-of-range fields
        add_pair(mk(1, 1, 1, 0, 0, 0), mk(1, 1, 1, 0, 0, 0));
        add_pair(mk(1, 1, 1, 0, 0, 0), mk(9999, 12, 31, 23, 59, 59));
        add_pair(mk(9999, 12, 31, 23, 59, 59), mk(1, 1, 1, 0, 0, 0));
        add_pair(mk(2000, 2, 29, 12, 0, 0), mk(2000, 3, 1, 0, 0, 0));
        add_pair(mk(1900, 2, 28, 0, 0, 0), mk(1900, 3, 1, 0, 0, 0));
        add_pair(mk(2024, 2, 29, 0, 0, 1), mk(2024, 3, 1, 0, 0, 0));
        add_pair(mk(2023, 12, 31, 23, 59, 59), mk(2024, 1, 1, 0, 0, 0));
        add_pair(mk(0, 1, 1, 0, 0, 0), mk(1, 1, 1, 0, 0, 0));
        add_pair(mk(16383, 6, 15, 0, 0, 0), mk(9999, 6, 15, 0, 0, 0));
        add_pair(mk(2001, 0, 10, 1, 2, 3), mk(2001, 1, 10, 1, 2, 3));
        add_pair(mk(2001, 15, 10, 0, 0, 0), mk(2001, 12, 10, 0, 0, 0));
        add_pair(mk(2001, 2, 31, 0, 0, 0), mk(2001, 3, 3, 0, 0, 0));
        add_pair(mk(1, 1, 0, 0, 0, 0), mk(1, 1, 1, 0, 0, 0));
        add_pair(mk(500, 7, 4, 31, 63, 63), mk(500, 7, 4, 0, 0, 0));
        add_pair(mk(0, 0, 0, 0, 0, 0), mk(16383, 15, 31, 31, 63, 63));
        add_pair(mk(1600, 2, 29, 0, 0, 0), mk(1700, 2, 28, 0, 0, 0));
        add_pair(mk(1999, 5, 5, 5, 5, 5), mk(1999, 5, 5, 5, 6, 4));
        add_pair(mk(4, 3, 1, 0, 0, 0), mk(4, 2, 29, 0, 0, 0));
        n_wild = 8;

        // Random: plausible pairs, near-identical pairs and raw bit patterns
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            r = $urandom_range(0, 99);
            a = random_stamp();
            if (r < 50)
                b = random_stamp();
            else if (r < 80)
            begin
                b = a;
                case ($urandom_range(0, 3))
                    0:
                    begin
                        v     = $urandom_range(0, 59);
                        b.sec = v[tsd_pkg::SECOND_W-1:0];
                    end
                    1:
                    begin
                        v     = $urandom_range(1, 31);
                        b.day = v[tsd_pkg::DAY_W-1:0];
                    end
                    2:
                    begin
                        v      = $urandom_range(0, 23);
                        b.hour = v[tsd_pkg::HOUR_W-1:0];
                    end
                    default: b.year = (a.year < tsd_pkg::MAX_YEAR) ? a.year + 1'b1 : a.year;
                endcase
            end
            else
            begin
                a = wild_stamp();
                b = wild_stamp();
                n_wild++;
            end
            if ($urandom_range(0, 1) == 1)
                add_pair(a, b);
            else
                add_pair(b, a);
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        while (pending_pairs.size() != 0 || s_tvalid || n_acc != n_got)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (expected_diffs.size() != 0)
        begin
            $display("%0d expected result words never arrived", expected_diffs.size());
            n_err += expected_diffs.size();
        end

        $display("Checked %0d difference words; %0d pairs had out-of-range fields.",
                 n_got, n_wild);
        $display("Ran with input bursts, a %0d-cycle output hold and a full drain.",
                 HOLD_CYCLES);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Drive pair words; note each accepted word for the checker
    always @(posedge clk or negedge rst_n)
    begin
        pair_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            acc_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                acc_valid <= 1'b1;
                acc_word  <= s_tdata;
                n_acc     <= n_acc + 1;
            end
            else
                acc_valid <= 1'b0;

            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_pairs.size() > 0
                         && !(pending_pairs[0].drain_first && (s_tvalid || n_acc != n_got)))
                begin
                    it = pending_pairs.pop_front();
                    s_tdata  <= it.pair;
                    s_tvalid <= 1'b1;
                    gap_left = it.gap_after;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result side: random stalls, free stretches and one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else if (!hold_done && n_got >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if ((cyc % 1500) < 300)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin
        diff_word_t want;
        diff_word_t got;
        if (rst_n)
        begin
            if (acc_valid)
                expected_diffs.push_back(predict_difference(stamp_pair_t'(acc_word)));
            if (m_tvalid && m_tready)
            begin
                n_got <= n_got + 1;
                got = diff_word_t'(m_tdata);
                if (expected_diffs.size() == 0)
                begin
                    if (n_err < 10)
                        $display("Unexpected result word %h", m_tdata);
                    n_err++;
                end
                else
                begin
                    want = expected_diffs.pop_front();
                    if (got.hours !== want.hours || got.mins !== want.mins
                        || got.secs !== want.secs)
                    begin
                        if (n_err < 10)
                            $display("Word %0d: expected %0d h %0d m %0d s, got %0d h %0d m %0d s",
                                     n_got, want.hours, want.mins, want.secs,
                                     got.hours, got.mins, got.secs);
                        n_err++;
                    end
                end
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
